[hw/rtl/irc_message_tokenizer_unit_defines.svh]
// Assertion macros for the IRC message tokenizer checker.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef IRC_MESSAGE_TOKENIZER_UNIT_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define IRC_TOK_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define IRC_TOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/irc_tok_pkg.sv]
// Shared types and constants for the IRC message tokenizer.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package irc_tok_pkg;

  localparam int MAX_PARAMS = 16;
  // Highest parameter index; the 4-bit index field caps it at 15.
  localparam logic [3:0] PARAM_LIMIT =
    4'(((MAX_PARAMS - 1) > 15) ? 15 : (MAX_PARAMS - 1));

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_MSG_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FIELD_PREFIX  = 2'd0,
    FIELD_COMMAND = 2'd1,
    FIELD_PARAM   = 2'd2
  } field_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_CMD   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    field_t     field;
    logic [3:0] param_index;
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  // Up to two results caused by one input byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

[hw/rtl/irc_tok_if.sv]
// Channel interfaces of the IRC message tokenizer: byte input and token output.
// Depends on irc_tok_pkg.
interface irc_tok_in_if import irc_tok_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_terminator;

  modport source (output valid, output data_byte, output is_terminator, input ready);
  modport sink   (input valid, input data_byte, input is_terminator, output ready);
endinterface

interface irc_tok_out_if import irc_tok_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  field_t     field;
  logic [3:0] param_index;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output field, output param_index,
                  output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input kind, input field, input param_index,
                  input out_byte, input last_of_run, output ready);
endinterface

[hw/rtl/irc_message_tokenizer_unit.sv]
// Top level of the IRC message tokenizer: parser plus a four-entry result queue.
// Depends on irc_tok_pkg, irc_tok_if and irc_tok_parse.
//
// The block takes one message byte per clock cycle while in_ch.ready is high
// and emits tagged data bytes, token ends and message ends. A byte is decoded in
// the cycle it is accepted and its results are written into a four-entry result
// queue, whose head drives the output. Most bytes give zero or one result; a
// terminator that closes a token, or the first character after a gap in the
// trailing parameter, gives two, which leave the queue one after the other.
// in_ch.ready is high whenever the queue has at least two free entries, so with
// the output always ready the input sustains one byte per cycle, and the output
// port of the queue (one result per cycle) is what sets the long-term rate when
// two-result bytes come often. No memory needs clearing after reset.
module irc_message_tokenizer_unit import irc_tok_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  irc_tok_in_if.sink    in_ch,
  irc_tok_out_if.source out_ch
);

  step_t               step;
  logic                in_fire;
  logic                out_fire;
  logic [FIFO_CW-1:0]  count_r,  count_nxt;
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          push_n;
  result_t             fifo_mem [FIFO_DEPTH];
  result_t             head;

  assign in_ch.ready = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  irc_tok_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_fire),
    .data_byte     (in_ch.data_byte),
    .is_terminator (in_ch.is_terminator),
    .step          (step)
  );

  always_comb begin
    push_n     = in_fire ? step.count : 2'd0;
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(out_fire);
    count_nxt  = count_r + FIFO_CW'(push_n) - FIFO_CW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) fifo_mem[wr_ptr_r] <= step.res0;
    if (push_n == 2'd2) fifo_mem[wr_ptr_r + FIFO_AW'(1)] <= step.res1;
  end

  assign head               = fifo_mem[rd_ptr_r];
  assign out_ch.valid       = (count_r != '0);
  assign out_ch.kind        = head.kind;
  assign out_ch.field       = head.field;
  assign out_ch.param_index = head.param_index;
  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.last_of_run = head.last_of_run;

endmodule

[hw/rtl/irc_tok_parse.sv]
// Parser state and per-byte decode of the IRC message tokenizer.
// Depends on irc_tok_pkg.
module irc_tok_parse import irc_tok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       is_terminator,
  output step_t      step
);

  phase_t     phase_r,  phase_nxt;
  logic       inside_r, inside_nxt;
  logic [3:0] pcount_r, pcount_nxt;
  logic       trail_r,  trail_nxt;
  logic       spend_r,  spend_nxt;

  field_t     cur_field;
  logic [3:0] cur_idx;
  result_t    cur_data;
  result_t    cur_tend;
  result_t    msg_end;

  always_comb begin
    case (phase_r)
      PH_START: cur_field = FIELD_PREFIX;
      PH_CMD:   cur_field = FIELD_COMMAND;
      default:  cur_field = FIELD_PARAM;
    endcase
    cur_idx = (cur_field == FIELD_PARAM) ? pcount_r : 4'd0;

    cur_data = '{kind: KIND_DATA, field: cur_field, param_index: cur_idx,
                 out_byte: data_byte, last_of_run: 1'b0};
    cur_tend = '{kind: KIND_TOKEN_END, field: cur_field, param_index: cur_idx,
                 out_byte: 8'd0, last_of_run: 1'b0};
    msg_end  = '{kind: KIND_MSG_END, field: FIELD_PREFIX, param_index: 4'd0,
                 out_byte: 8'd0, last_of_run: 1'b0};
  end

  always_comb begin
    phase_nxt  = phase_r;
    inside_nxt = inside_r;
    pcount_nxt = pcount_r;
    trail_nxt  = trail_r;
    spend_nxt  = spend_r;
    step.count = 2'd0;
    step.res0  = cur_data;
    step.res1  = cur_data;

    if (is_terminator) begin
      if (inside_r || trail_r) begin
        step.res0  = cur_tend;
        step.res1  = msg_end;
        step.count = 2'd2;
      end else begin
        step.res0  = msg_end;
        step.count = 2'd1;
      end
      phase_nxt  = PH_START;
      inside_nxt = 1'b0;
      pcount_nxt = 4'd0;
      trail_nxt  = 1'b0;
      spend_nxt  = 1'b0;
    end else if (data_byte == SPACE_CHAR) begin
      if (inside_r) begin
        // Inside the trailing parameter a gap only leaves a joining space behind.
        if (trail_r) begin
          spend_nxt = 1'b1;
        end else begin
          step.res0  = cur_tend;
          step.count = 2'd1;
          case (phase_r)
            PH_START: phase_nxt = PH_CMD;
            PH_CMD:   phase_nxt = PH_PARAM;
            default: begin
              if (pcount_r < PARAM_LIMIT) pcount_nxt = pcount_r + 4'd1;
            end
          endcase
        end
        inside_nxt = 1'b0;
      end
    end else if (inside_r) begin
      step.count = 2'd1;
    end else begin
      inside_nxt = 1'b1;
      case (phase_r)
        PH_START: begin
          // A leading colon opens the prefix and is stripped.
          if (data_byte != COLON_CHAR) begin
            phase_nxt       = PH_CMD;
            step.res0.field = FIELD_COMMAND;
            step.count      = 2'd1;
          end
        end
        PH_CMD: begin
          step.count = 2'd1;
        end
        default: begin
          if (trail_r) begin
            if (spend_r) begin
              step.res0.out_byte = SPACE_CHAR;
              step.count         = 2'd2;
            end else begin
              step.count = 2'd1;
            end
            spend_nxt = 1'b0;
          end else if (data_byte == COLON_CHAR) begin
            trail_nxt = 1'b1;
            spend_nxt = 1'b0;
          end else begin
            step.count = 2'd1;
          end
        end
      endcase
    end

    step.res0.last_of_run = (step.count == 2'd1);
    step.res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      inside_r <= 1'b0;
      pcount_r <= 4'd0;
      trail_r  <= 1'b0;
      spend_r  <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      inside_r <= inside_nxt;
      pcount_r <= pcount_nxt;
      trail_r  <= trail_nxt;
      spend_r  <= spend_nxt;
    end
  end

endmodule

[hw/rtl/irc_tok_checker.sv]
// Port-level assertions for the IRC message tokenizer, bound to the top level.
// Depends on irc_tok_pkg and irc_message_tokenizer_unit_defines.svh.
`include "irc_message_tokenizer_unit_defines.svh"

module irc_tok_checker import irc_tok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [1:0] field,
  input  logic [3:0] param_index,
  input  logic [7:0] out_byte,
  input  logic       last_of_run
);

  `IRC_TOK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(kind) && $stable(field) && $stable(param_index) &&
    $stable(out_byte) && $stable(last_of_run), "stalled output item changed")

  `IRC_TOK_ASSERT_IMPLY(a_msg_end_clean, out_valid && (kind == KIND_MSG_END),
    (field == FIELD_PREFIX) && (param_index == 4'd0) && (out_byte == 8'd0) &&
    last_of_run, "message end item is not clean or not last of its run")

  `IRC_TOK_ASSERT_IMPLY(a_ctrl_no_byte, out_valid && (kind != KIND_DATA),
    out_byte == 8'd0, "token or message end carries a byte")

  `IRC_TOK_ASSERT_IMPLY(a_index_param_only, out_valid && (field != FIELD_PARAM),
    param_index == 4'd0, "prefix or command item carries a parameter index")

endmodule

bind irc_message_tokenizer_unit irc_tok_checker u_irc_tok_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .field       (out_ch.field),
  .param_index (out_ch.param_index),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run)
);
